### src/cosdo_pkg.sv
`default_nettype none

package cosdo_pkg;

  typedef struct packed {
    logic [2:0]         operation;
    logic [10:0]        rx_id;
    logic [31:0]        rx_data_high;
    logic signed [23:0] current_ma;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [10:0] tx_id;
    logic [63:0] tx_payload;
    logic        done_res;
    logic [2:0]  done_code;
    logic [1:0]  drive_state;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_free;
  } dp_sts_t;

  localparam logic [2:0] OP_TICK        = 3'd0;
  localparam logic [2:0] OP_RX_FRAME    = 3'd1;
  localparam logic [2:0] OP_INIT        = 3'd2;
  localparam logic [2:0] OP_START       = 3'd3;
  localparam logic [2:0] OP_STOP        = 3'd4;
  localparam logic [2:0] OP_SET_CURRENT = 3'd5;

  localparam logic [2:0] DONE_OK        = 3'd0;
  localparam logic [2:0] DONE_TIMEOUT   = 3'd1;
  localparam logic [2:0] DONE_WRONG     = 3'd2;
  localparam logic [2:0] DONE_STUCK     = 3'd3;
  localparam logic [2:0] DONE_BUSY      = 3'd4;

  localparam logic [1:0] ST_OFF         = 2'd0;
  localparam logic [1:0] ST_INIT        = 2'd1;
  localparam logic [1:0] ST_MOTOR_OFF   = 2'd2;
  localparam logic [1:0] ST_MOTOR_ON    = 2'd3;

  localparam logic [2:0] RQ_NONE        = 3'd0;
  localparam logic [2:0] RQ_PROBE       = 3'd1;
  localparam logic [2:0] RQ_MAXREAD     = 3'd2;
  localparam logic [2:0] RQ_INITSTOP    = 3'd3;
  localparam logic [2:0] RQ_START       = 3'd4;
  localparam logic [2:0] RQ_STOP        = 3'd5;
  localparam logic [2:0] RQ_CURRENT     = 3'd6;

  localparam logic CFG_NODE_INDEX    = 1'b0;
  localparam logic CFG_TIMEOUT_TICKS = 1'b1;

  localparam logic [6:0]  NODE_RESET    = 7'd1;
  localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

  localparam logic [10:0] ID_RESPONSE   = 11'h580;
  localparam logic [10:0] ID_REQUEST    = 11'h600;

  localparam logic [63:0] FR_PROBE   = 64'h0000_0000_0060_4148;
  localparam logic [63:0] FR_MAXREAD = 64'h0000_0000_0060_7540;
  localparam logic [63:0] FR_START   = 64'h0000_000F_0060_402B;
  localparam logic [63:0] FR_STOP    = 64'h0000_0006_0060_402B;
  localparam logic [31:0] FR_CURRENT_LO = 32'h0060_712B;

  localparam logic [9:0] MA_SCALE = 10'd1000;

  localparam int DIV_W     = 35;
  localparam int DIV_STEPS = DIV_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

endpackage

`default_nettype wire

### src/cosdo_ctrl.sv
`default_nettype none

module cosdo_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire cosdo_pkg::dp_sts_t sts,
  output cosdo_pkg::dp_cmd_t     cmd
);
  import cosdo_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EVAL  = 5'b00010,
    S_MUL   = 5'b00100,
    S_DIV   = 5'b01000,
    S_WRITE = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = sts.need_div ? S_MUL : S_WRITE;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = CNT_W'(DIV_STEPS - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### src/cosdo_dpath.sv
`default_nettype none

module cosdo_dpath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cosdo_pkg::in_item_t in_data,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [31:0]         cfg_data,
  input  wire cosdo_pkg::dp_cmd_t  cmd,
  output cosdo_pkg::dp_sts_t       sts,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output cosdo_pkg::out_item_t     out_data
);
  import cosdo_pkg::*;

  in_item_t           item_r;
  logic [6:0]         node_r;
  logic [31:0]        timeout_r;
  logic [1:0]         status_r, status_nxt;
  logic [2:0]         pend_r, pend_nxt;
  logic [31:0]        wait_r, wait_nxt;
  logic [31:0]        maxc_r, maxc_nxt;
  logic [DIV_W-1:0]   quo_r;
  logic [DIV_W-3:0]   rem_r;
  logic               out_valid_r;
  out_item_t          out_r;
  out_item_t          res;

  logic               neg;
  logic [23:0]        mag;
  logic [33:0]        prod;
  logic [DIV_W-1:0]   num;
  logic [DIV_W-2:0]   rem_sh;
  logic [DIV_W-2:0]   den;
  logic               ge;
  logic [DIV_W-1:0]   q_clamp;
  logic [16:0]        q_lim;
  logic [16:0]        q_neg;
  logic [15:0]        cur_val;
  logic [10:0]        tx_id;
  logic [10:0]        rx_match_id;
  logic [31:0]        wait_inc;

  assign neg    = item_r.current_ma[23];
  assign mag    = neg ? (~item_r.current_ma + 24'd1) : item_r.current_ma;
  assign prod   = {10'd0, mag} * {24'd0, MA_SCALE};
  assign num    = {prod, 1'b0} + {3'd0, maxc_r};

  assign rem_sh = {rem_r, quo_r[DIV_W-1]};
  assign den    = {1'b0, maxc_r, 1'b0};
  assign ge     = (rem_sh >= den);

  assign q_clamp = (quo_r > {3'd0, maxc_r}) ? {3'd0, maxc_r} : quo_r;
  assign q_lim   = (q_clamp > DIV_W'(32768)) ? 17'd32768 : q_clamp[16:0];
  assign q_neg   = ~q_lim + 17'd1;
  always_comb begin
    if (neg) begin
      cur_val = q_neg[15:0];
    end else if (q_lim > 17'd32767) begin
      cur_val = 16'h7FFF;
    end else begin
      cur_val = q_lim[15:0];
    end
  end

  assign tx_id       = ID_REQUEST + {4'd0, node_r};
  assign rx_match_id = ID_RESPONSE + {4'd0, node_r};
  assign wait_inc    = wait_r + 32'd1;

  assign sts.need_div = (item_r.operation == OP_SET_CURRENT) && (pend_r == RQ_NONE) &&
                        (status_r == ST_MOTOR_ON) && (maxc_r != '0);
  assign sts.out_free = !out_valid_r || !out_stall;

  always_comb begin
    res        = '0;
    status_nxt = status_r;
    pend_nxt   = pend_r;
    wait_nxt   = wait_r;
    maxc_nxt   = maxc_r;
    case (item_r.operation)
      OP_TICK: begin
        if (pend_r != RQ_NONE) begin
          wait_nxt = wait_inc;
          if (wait_inc >= timeout_r) begin
            wait_nxt     = '0;
            pend_nxt     = RQ_NONE;
            res.done_res = 1'b1;
            case (pend_r)
              RQ_PROBE, RQ_START, RQ_CURRENT: begin
                status_nxt    = ST_OFF;
                res.done_code = DONE_TIMEOUT;
              end
              RQ_MAXREAD: begin
                res.done_res   = 1'b0;
                res.tx_valid   = 1'b1;
                res.tx_id      = tx_id;
                res.tx_payload = FR_STOP;
                pend_nxt       = RQ_INITSTOP;
              end
              RQ_INITSTOP: begin
                res.done_code = DONE_STUCK;
              end
              default: begin
                res.done_code = DONE_TIMEOUT;
              end
            endcase
          end
        end
      end
      OP_RX_FRAME: begin
        if (pend_r != RQ_NONE && item_r.rx_id == rx_match_id) begin
          wait_nxt = '0;
          case (pend_r)
            RQ_PROBE: begin
              status_nxt     = ST_INIT;
              res.tx_valid   = 1'b1;
              res.tx_id      = tx_id;
              res.tx_payload = FR_MAXREAD;
              pend_nxt       = RQ_MAXREAD;
            end
            RQ_MAXREAD: begin
              maxc_nxt       = item_r.rx_data_high;
              res.tx_valid   = 1'b1;
              res.tx_id      = tx_id;
              res.tx_payload = FR_STOP;
              pend_nxt       = RQ_INITSTOP;
            end
            RQ_INITSTOP, RQ_STOP: begin
              status_nxt   = ST_MOTOR_OFF;
              res.done_res = 1'b1;
              pend_nxt     = RQ_NONE;
            end
            RQ_START: begin
              status_nxt   = ST_MOTOR_ON;
              res.done_res = 1'b1;
              pend_nxt     = RQ_NONE;
            end
            default: begin
              res.done_res = 1'b1;
              pend_nxt     = RQ_NONE;
            end
          endcase
        end
      end
      OP_INIT, OP_START, OP_STOP, OP_SET_CURRENT: begin
        if (pend_r != RQ_NONE) begin
          res.done_res  = 1'b1;
          res.done_code = DONE_BUSY;
        end else begin
          wait_nxt = '0;
          case (item_r.operation)
            OP_INIT: begin
              res.tx_valid   = 1'b1;
              res.tx_id      = tx_id;
              res.tx_payload = FR_PROBE;
              pend_nxt       = RQ_PROBE;
            end
            OP_START: begin
              if (status_r != ST_MOTOR_OFF) begin
                res.done_res  = 1'b1;
                res.done_code = DONE_WRONG;
              end else begin
                res.tx_valid   = 1'b1;
                res.tx_id      = tx_id;
                res.tx_payload = FR_START;
                pend_nxt       = RQ_START;
              end
            end
            OP_STOP: begin
              res.tx_valid   = 1'b1;
              res.tx_id      = tx_id;
              res.tx_payload = FR_STOP;
              pend_nxt       = RQ_STOP;
            end
            default: begin
              if (status_r != ST_MOTOR_ON || maxc_r == '0) begin
                res.done_res  = 1'b1;
                res.done_code = DONE_WRONG;
              end else begin
                res.tx_valid   = 1'b1;
                res.tx_id      = tx_id;
                res.tx_payload = {16'd0, cur_val, FR_CURRENT_LO};
                pend_nxt       = RQ_CURRENT;
              end
            end
          endcase
        end
      end
      default: begin
      end
    endcase
    res.drive_state = status_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.mul) begin
      quo_r <= num;
      rem_r <= '0;
    end else if (cmd.step) begin
      quo_r <= {quo_r[DIV_W-2:0], ge};
      rem_r <= ge ? rem_sh[DIV_W-3:0] - den[DIV_W-3:0] : rem_sh[DIV_W-3:0];
    end
    if (cmd.commit) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_r      <= NODE_RESET;
      timeout_r   <= TIMEOUT_RESET;
      status_r    <= ST_OFF;
      pend_r      <= RQ_NONE;
      wait_r      <= '0;
      maxc_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_NODE_INDEX:    node_r    <= cfg_data[6:0];
          CFG_TIMEOUT_TICKS: timeout_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.commit) begin
        status_r    <= status_nxt;
        pend_r      <= pend_nxt;
        wait_r      <= wait_nxt;
        maxc_r      <= maxc_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### src/canopen_sdo_drive_sequencer.sv
// A result passes from its input register through S_EVAL and S_WRITE; a set-current
// command that sends a frame also passes S_MUL and the 35 one-bit steps of the divider.
// An item is taken only once the previous result is committed to the output register.
// A result waiting in the output register does not block the next input transfer.
// Reset (synchronous, rst_n low) clears the sequencer to off with nothing outstanding and
// loads node index 1 and a timeout of 1000 ticks.
`default_nettype none

module canopen_sdo_drive_sequencer (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire cosdo_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output cosdo_pkg::out_item_t      out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic                 cfg_index,
  input  wire logic [31:0]          cfg_data
);
  import cosdo_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  cosdo_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  cosdo_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### tb/canopen_sdo_drive_sequencer_test.sv
`timescale 1ns / 1ps

module canopen_sdo_drive_sequencer_test;
  import cosdo_pkg::*;

  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  canopen_sdo_drive_sequencer uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Mirror of the sequencer state and its registers.
  logic [1:0] drv_state = ST_OFF;
  logic [2:0] open_req = RQ_NONE;
  logic [31:0] tick_count = '0;
  logic [31:0] max_ma = '0;
  logic [6:0] node_id = NODE_RESET;
  logic [31:0] tmo_ticks = TIMEOUT_RESET;

  in_item_t drive_items[$];
  out_item_t due_outputs[$];
  int queued = 0;
  int err_count = 0;
  int quiet_cycles = 0;
  bit quiet = 1'b0;

  function automatic void send_req(inout out_item_t r, input logic [63:0] frame,
                                   input logic [2:0] kind);
    r.tx_valid = 1'b1;
    r.tx_id = ID_REQUEST + 11'(node_id);
    r.tx_payload = frame;
    open_req = kind;
    tick_count = '0;
  endfunction

  function automatic void end_req(inout out_item_t r, input logic [2:0] code);
    r.done_res = 1'b1;
    r.done_code = code;
    open_req = RQ_NONE;
    tick_count = '0;
  endfunction

  function automatic logic [63:0] current_frame(input logic signed [23:0] ma);
    logic signed [63:0] sma;
    logic signed [63:0] v;
    logic [63:0] mag;
    logic [63:0] q;
    logic [63:0] lim;
    sma = ma;
    mag = (sma < 0) ? 64'(-sma) : 64'(sma);
    mag = mag * 64'd1000;
    lim = {32'd0, max_ma};
    q = (2 * mag + lim) / (2 * lim);
    if (q > lim) q = lim;
    if (q > 64'd32768) q = 64'd32768;
    v = (sma < 0) ? -$signed(q) : $signed(q);
    if (v > 32767) v = 32767;
    return {16'h0000, v[15:0], FR_CURRENT_LO};
  endfunction

  function automatic out_item_t sequencer_step(input in_item_t it);
    out_item_t r;
    r = '0;
    case (it.operation)
      OP_TICK: begin
        if (open_req != RQ_NONE) begin
          tick_count = tick_count + 1;
          if (tick_count >= tmo_ticks) begin
            case (open_req)
              RQ_PROBE, RQ_START, RQ_CURRENT: begin
                drv_state = ST_OFF;
                end_req(r, DONE_TIMEOUT);
              end
              RQ_MAXREAD: send_req(r, FR_STOP, RQ_INITSTOP);
              RQ_INITSTOP: end_req(r, DONE_STUCK);
              default: end_req(r, DONE_TIMEOUT);
            endcase
          end
        end
      end
      OP_RX_FRAME: begin
        if (open_req != RQ_NONE && it.rx_id == ID_RESPONSE + 11'(node_id)) begin
          case (open_req)
            RQ_PROBE: begin
              drv_state = ST_INIT;
              send_req(r, FR_MAXREAD, RQ_MAXREAD);
            end
            RQ_MAXREAD: begin
              max_ma = it.rx_data_high;
              send_req(r, FR_STOP, RQ_INITSTOP);
            end
            RQ_INITSTOP, RQ_STOP: begin
              drv_state = ST_MOTOR_OFF;
              end_req(r, DONE_OK);
            end
            RQ_START: begin
              drv_state = ST_MOTOR_ON;
              end_req(r, DONE_OK);
            end
            default: end_req(r, DONE_OK);
          endcase
        end
      end
      OP_INIT, OP_START, OP_STOP, OP_SET_CURRENT: begin
        if (open_req != RQ_NONE) begin
          r.done_res = 1'b1;
          r.done_code = DONE_BUSY;
        end else begin
          case (it.operation)
            OP_INIT: send_req(r, FR_PROBE, RQ_PROBE);
            OP_START: begin
              if (drv_state != ST_MOTOR_OFF) end_req(r, DONE_WRONG);
              else send_req(r, FR_START, RQ_START);
            end
            OP_STOP: send_req(r, FR_STOP, RQ_STOP);
            default: begin
              if (drv_state != ST_MOTOR_ON || max_ma == 0) end_req(r, DONE_WRONG);
              else send_req(r, current_frame(it.current_ma), RQ_CURRENT);
            end
          endcase
        end
      end
      default: ;
    endcase
    r.drive_state = drv_state;
    return r;
  endfunction

  function automatic void check_field(input string what, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) due_outputs.push_back(sequencer_step(in_data));
      if (!in_valid || !in_stall) begin
        if (drive_items.size() > 0 && (quiet || $urandom_range(99) >= 14)) begin
          in_valid <= 1'b1;
          in_data <= drive_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    out_item_t want;
    if (rst_n) begin
      out_stall <= !quiet && ($urandom_range(99) < 14);
      if (out_valid && !out_stall) begin
        if (due_outputs.size() == 0) begin
          $display("%0t: unexpected result transfer: expected none, actual %0h", $time,
                   out_data);
          err_count++;
        end else begin
          want = due_outputs.pop_front();
          check_field("tx_valid", want.tx_valid, out_data.tx_valid);
          check_field("tx_id", want.tx_id, out_data.tx_id);
          check_field("tx_payload", want.tx_payload, out_data.tx_payload);
          check_field("done_res", want.done_res, out_data.done_res);
          check_field("done_code", want.done_code, out_data.done_code);
          check_field("drive_state", want.drive_state, out_data.drive_state);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("canopen_sdo_drive_sequencer_test: FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_NODE_INDEX) node_id = val[6:0];
    else tmo_ticks = val;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (drive_items.size() != 0 || in_valid || due_outputs.size() != 0);
  endtask

  task automatic put(input in_item_t x);
    drive_items.push_back(x);
    queued++;
  endtask

  function automatic in_item_t mk(input logic [2:0] op);
    in_item_t x;
    x.operation = op;
    x.rx_id = 11'($urandom_range(2047));
    x.rx_data_high = $urandom;
    x.current_ma = 24'($urandom);
    return x;
  endfunction

  function automatic in_item_t reply(input logic [31:0] data);
    in_item_t x;
    x = mk(OP_RX_FRAME);
    x.rx_id = ID_RESPONSE + 11'(node_id);
    x.rx_data_high = data;
    return x;
  endfunction

  function automatic in_item_t set_current(input logic signed [23:0] ma);
    in_item_t x;
    x = mk(OP_SET_CURRENT);
    x.current_ma = ma;
    return x;
  endfunction

  function automatic logic [31:0] pick_max();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return $urandom;
      2: return $urandom_range(1, 10);
      3: return $urandom_range(32768, 70000);
      default: return $urandom_range(100, 30000);
    endcase
  endfunction

  function automatic logic signed [23:0] pick_ma();
    logic signed [23:0] x;
    case ($urandom_range(7))
      0: x = 24'sh7FFFFF;
      1: x = 24'sh800000;
      2: x = '0;
      3: begin
        x = 24'($urandom_range(2000));
        if ($urandom_range(1)) x = -x;
      end
      default: x = 24'($urandom);
    endcase
    return x;
  endfunction

  task automatic push_noise();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: put(mk(OP_TICK));
      5, 6: put(mk(OP_RX_FRAME));
      7: put(mk(3'($urandom_range(7))));
      default: put(mk(3'($urandom_range(OP_INIT, OP_SET_CURRENT))));
    endcase
  endtask

  task automatic maybe_noise();
    if ($urandom_range(99) < 30) repeat ($urandom_range(1, 3)) push_noise();
  endtask

  // A reply is sometimes withheld so that ticks can run the request into a timeout.
  task automatic answer(input logic [31:0] data);
    if ($urandom_range(9) == 0) repeat ($urandom_range(1, 6)) put(mk(OP_TICK));
    else put(reply(data));
  endtask

  task automatic gen_phase(input int n);
    int stop_at;
    stop_at = queued + n;
    while (queued < stop_at) begin
      case ($urandom_range(9))
        0, 1: begin
          put(mk(OP_INIT));
          maybe_noise();
          answer($urandom);
          maybe_noise();
          answer(pick_max());
          maybe_noise();
          answer($urandom);
        end
        2, 3: begin
          put(mk(OP_START));
          maybe_noise();
          answer($urandom);
        end
        4, 5, 6: begin
          put(set_current(pick_ma()));
          maybe_noise();
          answer($urandom);
        end
        7: begin
          put(mk(OP_STOP));
          maybe_noise();
          answer($urandom);
        end
        8: repeat ($urandom_range(1, 8)) put(mk(OP_TICK));
        default: push_noise();
      endcase
    end
  endtask

  initial begin : stimulus
    in_item_t x;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Commands in the wrong state, ignored items, then a full init, start, currents and stop.
    put(set_current(24'sd100));
    put(mk(OP_START));
    put(mk(OP_TICK));
    put(reply($urandom));
    put(mk(OP_SPARE_A));
    put(mk(OP_SPARE_B));
    put(mk(OP_INIT));
    put(mk(OP_START));
    x = reply($urandom);
    x.rx_id = ID_RESPONSE + 11'(node_id) + 11'd1;
    put(x);
    put(reply(32'hFFFF_FFFF));
    put(reply(32'd40000));
    put(reply(32'h0));
    put(mk(OP_START));
    put(reply(32'h0));
    put(set_current(24'sh7FFFFF));
    put(reply(32'h0));
    put(set_current(24'sh800000));
    put(mk(OP_TICK));
    put(reply(32'h0));
    put(mk(OP_STOP));
    put(reply(32'h0));
    wait_drained();

    // Every request times out on its first tick.
    write_reg(CFG_NODE_INDEX, 32'd127);
    write_reg(CFG_TIMEOUT_TICKS, 32'd0);
    @(negedge clk);
    put(mk(OP_INIT));
    put(mk(OP_TICK));
    put(mk(OP_INIT));
    put(reply($urandom));
    put(mk(OP_TICK));
    put(mk(OP_TICK));
    put(mk(OP_STOP));
    put(mk(OP_TICK));
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) begin
        write_reg(CFG_NODE_INDEX, 32'd0);
        write_reg(CFG_TIMEOUT_TICKS, 32'hFFFF_FFFF);
      end else begin
        case ($urandom_range(3))
          0: write_reg(CFG_NODE_INDEX, 32'd0);
          1: write_reg(CFG_NODE_INDEX, 32'd127);
          default: write_reg(CFG_NODE_INDEX, $urandom);
        endcase
        case ($urandom_range(5))
          0: write_reg(CFG_TIMEOUT_TICKS, 32'd0);
          1: write_reg(CFG_TIMEOUT_TICKS, 32'hFFFF_FFFF);
          2: write_reg(CFG_TIMEOUT_TICKS, $urandom);
          default: write_reg(CFG_TIMEOUT_TICKS, $urandom_range(1, 6));
        endcase
      end
      @(negedge clk);
      quiet = (ph == 3);
      gen_phase(75);
      wait_drained();
    end

    repeat (50) @(negedge clk);
    if (err_count == 0) begin
      $display("canopen_sdo_drive_sequencer_test: PASS");
    end else begin
      $display("canopen_sdo_drive_sequencer_test: FAIL");
    end
    $finish;
  end

endmodule
